// File: sv/cdfs_pkg.sv
// Shared types and constants for the camera dark fraction statistics block.
package cdfs_pkg;

  // Field and state widths
  localparam int CH_W     = 8;
  localparam int WGT_W    = 16;
  localparam int LUMA_W   = 24;
  localparam int THR_W    = 25;
  localparam int CNT_W    = 25;
  localparam int SUM_W    = 48;
  localparam int MEAN_W   = 24;
  localparam int FRAC_W   = 17;
  localparam int FRAC_SH  = 16;
  localparam int DSTEP_W  = $clog2(SUM_W);

  // Frame size limit, counters saturate here
  localparam logic [CNT_W-1:0] PIXEL_LIMIT = CNT_W'(16777216);

  // BT.601 weights in Q0.16 (0.299, 0.587, 0.114), sum is 65536
  localparam logic [WGT_W-1:0] WEIGHT_RED   = WGT_W'(19595);
  localparam logic [WGT_W-1:0] WEIGHT_GREEN = WGT_W'(38470);
  localparam logic [WGT_W-1:0] WEIGHT_BLUE  = WGT_W'(7471);

  // Threshold after reset: 128.0 in Q8.16
  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(8388608);

  // Last iteration of the serial divider
  localparam logic [DSTEP_W-1:0] DIV_LAST = DSTEP_W'(SUM_W - 1);

  // Channel selected for the shared multiplier
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_sel_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: sv/cdfs_divider.sv
// Restoring serial divider, one quotient bit per cycle, shared by both frame-end quotients.
module cdfs_divider
  import cdfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output div_status_t      status,
  output logic [SUM_W-1:0] quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DSTEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   dvs_r, dvs_nxt;

  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               fits;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits CNT_W bits
      rem_nxt  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// File: sv/camera_dark_fraction_stats_unit.sv
// Per-frame luma mean and dark pixel fraction over an RGB pixel stream.
// A pixel that does not end a frame passes through accept, three passes of
// the shared 16x8 multiplier and one accumulate step; no new pixel is taken
// until it is done. A frame-end pixel adds two 48-step runs of the serial
// divider; a frame over the pixel limit skips the divider.
// Reset (rst_n low, synchronous) clears the frame counters and the result
// valid flag and returns the dark threshold to 128.0 in Q8.16.
module camera_dark_fraction_stats_unit
  import cdfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  input  logic              in_last_pixel,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [MEAN_W-1:0] out_mean_luma_q16,
  output logic [FRAC_W-1:0] out_dark_fraction_q16,
  output logic              out_reading_valid,

  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wr_data
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL      = 7'b0000010,
    ST_ACC      = 7'b0000100,
    ST_END      = 7'b0001000,
    ST_DIV_MEAN = 7'b0010000,
    ST_DIV_FRAC = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  chan_sel_t         ch_r, ch_nxt;

  logic [THR_W-1:0]  thr_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  dark_r, dark_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic              over_r, over_nxt;

  logic [CH_W-1:0]   red_r, green_r, blue_r;
  logic              last_r;
  logic [LUMA_W-1:0] luma_r, luma_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [MEAN_W-1:0] out_mean_r;
  logic [FRAC_W-1:0] out_frac_r;
  logic              out_rv_r;
  logic              load_out;

  logic [CH_W-1:0]   mul_ch;
  logic [WGT_W-1:0]  mul_w;
  logic [LUMA_W-1:0] mul_prod;

  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  div_status_t       div_st;
  logic [SUM_W-1:0]  div_quo;

  logic              in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Shared multiplier: one weighted channel per cycle
  always_comb begin
    case (ch_r)
      CH_RED: begin
        mul_ch = red_r;
        mul_w  = WEIGHT_RED;
      end
      CH_GREEN: begin
        mul_ch = green_r;
        mul_w  = WEIGHT_GREEN;
      end
      CH_BLUE: begin
        mul_ch = blue_r;
        mul_w  = WEIGHT_BLUE;
      end
      default: begin
        mul_ch = '0;
        mul_w  = '0;
      end
    endcase
  end

  assign mul_prod = LUMA_W'(mul_w) * LUMA_W'(mul_ch);

  // Divider operands: mean first, then dark count scaled by 2^16 for a Q1.16 fraction
  always_comb begin
    if (state_r == ST_END) begin
      div_dividend = sum_r;
    end else begin
      div_dividend = SUM_W'({dark_r, FRAC_SH'(0)});
    end
  end

  cdfs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (seen_r),
    .status   (div_st),
    .quotient (div_quo)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    sum_nxt       = sum_r;
    dark_nxt      = dark_r;
    seen_nxt      = seen_r;
    over_nxt      = over_r;
    luma_nxt      = luma_r;
    mean_nxt      = mean_r;
    frac_nxt      = frac_r;
    div_start     = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          luma_nxt  = '0;
          ch_nxt    = CH_RED;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        luma_nxt = luma_r + mul_prod;
        case (ch_r)
          CH_RED:   ch_nxt = CH_GREEN;
          CH_GREEN: ch_nxt = CH_BLUE;
          default:  state_nxt = ST_ACC;
        endcase
      end
      ST_ACC: begin
        // saturate at the limit and flag the frame
        if (seen_r >= PIXEL_LIMIT) begin
          over_nxt = 1'b1;
        end else begin
          sum_nxt  = sum_r + SUM_W'(luma_r);
          seen_nxt = seen_r + 1'b1;
          if ({1'b0, luma_r} < thr_r) begin
            dark_nxt = dark_r + 1'b1;
          end
        end
        state_nxt = last_r ? ST_END : ST_IDLE;
      end
      ST_END: begin
        if (over_r) begin
          mean_nxt  = '0;
          frac_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_st.done) begin
          mean_nxt  = div_quo[MEAN_W-1:0];
          div_start = 1'b1;
          state_nxt = ST_DIV_FRAC;
        end
      end
      ST_DIV_FRAC: begin
        if (div_st.done) begin
          frac_nxt  = div_quo[FRAC_W-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the result register to free up
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          dark_nxt      = '0;
          seen_nxt      = '0;
          over_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= CH_RED;
      thr_r       <= THRESH_RESET;
      sum_r       <= '0;
      dark_r      <= '0;
      seen_r      <= '0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      sum_r       <= sum_nxt;
      dark_r      <= dark_nxt;
      seen_r      <= seen_nxt;
      over_r      <= over_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      last_r  <= in_last_pixel;
    end
    luma_r <= luma_nxt;
    mean_r <= mean_nxt;
    frac_r <= frac_nxt;
    if (load_out) begin
      out_mean_r <= mean_r;
      out_frac_r <= frac_r;
      out_rv_r   <= !over_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mean_luma_q16     = out_mean_r;
  assign out_dark_fraction_q16 = out_frac_r;
  assign out_reading_valid     = out_rv_r;

  // Counters never pass the limit
  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= PIXEL_LIMIT)
    else $error("pixel count above limit");

  // Dark pixels are a subset of the counted pixels
  a_dark_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    dark_r <= seen_r)
    else $error("dark count above pixel count");

  // Divider only runs on a frame within the limit
  a_div_ok: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !over_r && seen_r != '0)
    else $error("divider started on invalid frame");

  // A division only starts on an idle divider
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // Invalid frames report zero statistics
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rv_r |-> out_mean_r == '0 && out_frac_r == '0)
    else $error("invalid frame with nonzero statistics");

endmodule
